// ===== hw/rtl/boll_pkg.sv =====
// Shared types for the bounded ordered list engine.
// Command codes, per-cell operation codes and the cell command struct.
// No dependencies.
package boll_pkg;

  // external field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RPOS_W  = 8;
  localparam int unsigned CNT_W   = 9;
  localparam logic [CNT_W-1:0] CAP_LIMIT_RESET = 9'd256;

  // command codes on op_i
  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } op_e;

  // operation applied by every cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_WR   = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: command sequencer, cell
// chain and first-match scan. Uses boll_pkg, boll_cell and boll_scan.
//
// Usage:
//   Command beats arrive on in_valid_i/in_stall_o with op_i, position_i and
//   value_i; one result beat per command leaves on out_valid_o/out_stall_i.
//   The list lives in a chain of CAPACITY cells; inserts and erases shift
//   every cell from the target position upward together.
//   Sequence: insert_at, erase_at, get, set and unused codes go straight
//   to the apply step; insert_sorted and find pass through a compare step,
//   a scan step and the apply step; remove_all finds and erases each match
//   in its own compare/scan/erase round, and its last round, which finds
//   no match, loads the result.
//   One command is taken at a time: in_stall_o stays high from accept
//   until the apply step that loads the result.
//   The result sits in an output register; the next command is taken while
//   it waits, and the apply step holds if the old result is still stalled.
//   capacity_limit is written through cfg_we_i/cfg_wdata_i; the user must
//   write it only while idle, the block itself does not enforce this. Reset
//   empties the list and sets capacity_limit to 256; entry contents are not cleared.
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [boll_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [boll_pkg::OP_W-1:0]     op_i,
  input  logic [boll_pkg::POS_W-1:0]    position_i,
  input  logic [boll_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [boll_pkg::RPOS_W-1:0]   result_position_o,
  output logic [boll_pkg::VALUE_W-1:0]  read_value_o,
  output logic [boll_pkg::CNT_W-1:0]    removed_count_o,
  output logic [boll_pkg::CNT_W-1:0]    item_count_o,
  output logic                          is_empty_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = (CW > boll_pkg::POS_W) ? CW : boll_pkg::POS_W;
  localparam logic [PW-1:0] CapP = PW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                     state_q;
  logic [boll_pkg::CNT_W-1:0] cap_q;
  logic [boll_pkg::OP_W-1:0]  op_q;
  logic [boll_pkg::POS_W-1:0] pos_q;
  logic [DW-1:0]              val_q;
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              removed_q;
  logic                       found_q;
  logic [IW-1:0]              first_q;

  logic                         out_valid_q;
  logic                         ok_q;
  logic [boll_pkg::RPOS_W-1:0]  rpos_q;
  logic [boll_pkg::VALUE_W-1:0] rval_q;
  logic [boll_pkg::CNT_W-1:0]   rcnt_q;
  logic [boll_pkg::CNT_W-1:0]   icnt_q;
  logic                         empty_q;

  // cell chain signals
  boll_pkg::cell_cmd_t cell_cmd;
  logic [PW-1:0]       apos;
  logic [PW-1:0]       count_p;
  logic [DW-1:0]       cell_val [CAPACITY];
  logic [DW-1:0]       cell_rd  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] scan_flags;
  logic                scan_found;
  logic [IW-1:0]       scan_first;
  logic [DW-1:0]       rd_bus;

  // apply-step results
  logic          accept;
  logic          out_free;
  logic          loop_rm;
  logic          go;
  logic          res_ok;
  logic [PW-1:0] res_pos;
  logic [DW-1:0] res_val;
  logic [CW-1:0] cnt_next;
  logic [PW-1:0] lim;
  logic [PW-1:0] pos_p;
  logic [PW-1:0] spos;
  logic          room;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign count_p  = PW'(count_q);
  assign pos_p    = PW'(pos_q);
  assign lim      = (PW'(cap_q) < CapP) ? PW'(cap_q) : CapP;
  assign room     = count_p < lim;
  assign spos     = found_q ? PW'(first_q) : count_p;
  assign loop_rm  = (op_q == boll_pkg::OP_REMOVE_ALL) && found_q;
  assign go       = (state_q == ST_APPLY) && (loop_rm || out_free);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] prev_v;
    logic [DW-1:0] next_v;
    if (i == 0) begin : g_head
      assign prev_v = val_q;
    end else begin : g_prev
      assign prev_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = '0;
    end else begin : g_next
      assign next_v = cell_val[i+1];
    end
    boll_cell #(
      .DW  (DW),
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .pos_i   (apos),
      .count_i (count_p),
      .value_i (val_q),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .value_o (cell_val[i]),
      .eq_o    (eq_vec[i]),
      .ge_o    (ge_vec[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // read bus for get: only the addressed cell drives nonzero
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // sorted insert looks for the first entry >= value, others for equality
  assign scan_flags = (op_q == boll_pkg::OP_INSERT_SORTED) ? ge_vec : eq_vec;

  boll_scan #(
    .N (CAPACITY)
  ) u_scan (
    .flags_i (scan_flags),
    .found_o (scan_found),
    .first_o (scan_first)
  );

  // apply step: cell command, new count and result fields
  always_comb begin
    cell_cmd.op     = boll_pkg::CELL_HOLD;
    cell_cmd.cmp_en = (state_q == ST_EVAL);
    apos            = pos_p;
    cnt_next        = count_q;
    res_ok          = 1'b0;
    res_pos         = '0;
    res_val         = '0;
    case (op_q)
      boll_pkg::OP_INSERT_AT: begin
        res_ok = (pos_p <= count_p) && room;
        if (res_ok) begin
          cell_cmd.op = boll_pkg::CELL_INS;
          cnt_next    = count_q + CW'(1);
        end
      end
      boll_pkg::OP_INSERT_SORTED: begin
        res_ok = room;
        apos   = spos;
        if (res_ok) begin
          cell_cmd.op = boll_pkg::CELL_INS;
          cnt_next    = count_q + CW'(1);
          res_pos     = spos;
        end
      end
      boll_pkg::OP_ERASE_AT: begin
        res_ok = pos_p < count_p;
        if (res_ok) begin
          cell_cmd.op = boll_pkg::CELL_DEL;
          cnt_next    = count_q - CW'(1);
        end
      end
      boll_pkg::OP_REMOVE_ALL: begin
        res_ok = 1'b1;
        apos   = PW'(first_q);
        if (found_q) begin
          cell_cmd.op = boll_pkg::CELL_DEL;
          cnt_next    = count_q - CW'(1);
        end
      end
      boll_pkg::OP_GET: begin
        res_ok = pos_p < count_p;
        if (res_ok) begin
          res_val = rd_bus;
        end
      end
      boll_pkg::OP_SET: begin
        res_ok = pos_p < count_p;
        if (res_ok) begin
          cell_cmd.op = boll_pkg::CELL_WR;
        end
      end
      boll_pkg::OP_FIND: begin
        res_ok = found_q;
        if (found_q) begin
          res_pos = PW'(first_q);
        end
      end
      default: begin
      end
    endcase
    // nothing moves unless the apply step actually fires
    if (!go) begin
      cell_cmd.op = boll_pkg::CELL_HOLD;
      cnt_next    = count_q;
    end
  end

  // sequencer, list count, config register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= boll_pkg::CAP_LIMIT_RESET;
      op_q        <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      count_q     <= '0;
      removed_q   <= '0;
      found_q     <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      rpos_q      <= '0;
      rval_q      <= '0;
      rcnt_q      <= '0;
      icnt_q      <= '0;
      empty_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // result beat: loaded by the final apply step, dropped once taken
      if ((state_q == ST_APPLY) && !loop_rm && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      count_q <= cnt_next;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q      <= op_i;
            pos_q     <= position_i;
            val_q     <= DW'(value_i);
            removed_q <= '0;
            if ((op_i == boll_pkg::OP_INSERT_SORTED) ||
                (op_i == boll_pkg::OP_REMOVE_ALL) ||
                (op_i == boll_pkg::OP_FIND)) begin
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_APPLY;
            end
          end
        end
        ST_EVAL: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          found_q <= scan_found;
          first_q <= scan_first;
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (loop_rm) begin
            // one match erased, look again
            removed_q <= removed_q + CW'(1);
            state_q   <= ST_EVAL;
          end else if (out_free) begin
            ok_q        <= res_ok;
            rpos_q      <= boll_pkg::RPOS_W'(res_pos);
            rval_q      <= boll_pkg::VALUE_W'(res_val);
            rcnt_q      <= (op_q == boll_pkg::OP_REMOVE_ALL) ?
                           boll_pkg::CNT_W'(removed_q) : '0;
            icnt_q      <= boll_pkg::CNT_W'(cnt_next);
            empty_q     <= (cnt_next == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign result_position_o = rpos_q;
  assign read_value_o      = rval_q;
  assign removed_count_o   = rcnt_q;
  assign item_count_o      = icnt_q;
  assign is_empty_o        = empty_q;

endmodule

// ===== hw/rtl/boll_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts to/from its
// neighbors, and registers its compare flags. Uses boll_pkg.
module boll_cell #(
  parameter int unsigned DW  = 32,
  parameter int unsigned PW  = 9,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  boll_pkg::cell_cmd_t cmd_i,
  input  logic [PW-1:0]       pos_i,
  input  logic [PW-1:0]       count_i,
  input  logic [DW-1:0]       value_i,
  input  logic [DW-1:0]       prev_i,
  input  logic [DW-1:0]       next_i,
  output logic [DW-1:0]       value_o,
  output logic                eq_o,
  output logic                ge_o,
  output logic [DW-1:0]       rd_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [DW-1:0] value_q;
  logic          eq_q;
  logic          ge_q;
  logic          live;

  assign live = (MyIdx < count_i);

  // entry update: shift up on insert, down on erase, direct write
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      boll_pkg::CELL_INS: begin
        if (MyIdx > pos_i) begin
          value_q <= prev_i;
        end else if (MyIdx == pos_i) begin
          value_q <= value_i;
        end
      end
      boll_pkg::CELL_DEL: begin
        if (MyIdx >= pos_i) begin
          value_q <= next_i;
        end
      end
      boll_pkg::CELL_WR: begin
        if (MyIdx == pos_i) begin
          value_q <= value_i;
        end
      end
      default: begin
      end
    endcase
  end

  // compare flags, only live entries count
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      eq_q <= live && (value_q == value_i);
      ge_q <= live && (value_i <= value_q);
    end
  end

  assign value_o = value_q;
  assign eq_o    = eq_q;
  assign ge_o    = ge_q;
  assign rd_o    = (MyIdx == pos_i) ? value_q : '0;

endmodule

// ===== hw/rtl/boll_scan.sv =====
// First-set search over the cell flag row: log-depth prefix OR and a
// one-hot to index encoder. No dependencies.
module boll_scan #(
  parameter int unsigned N = 256
) (
  input  logic [N-1:0]                 flags_i,
  output logic                         found_o,
  output logic [(N > 1 ? $clog2(N) : 1)-1:0] first_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned LG = (N > 1) ? $clog2(N) : 0;

  logic [N-1:0] lvl [LG+1];
  logic [N-1:0] first_hot;

  assign lvl[0] = flags_i;

  // prefix OR by recursive doubling
  for (genvar k = 0; k < LG; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  // keep only the lowest set flag
  for (genvar i = 0; i < N; i++) begin : g_hot
    if (i == 0) begin : g_first
      assign first_hot[i] = flags_i[i];
    end else begin : g_rest
      assign first_hot[i] = flags_i[i] & ~lvl[LG][i-1];
    end
  end

  assign found_o = lvl[LG][N-1];

  // encode the one-hot position
  always_comb begin
    first_o = '0;
    for (int i = 0; i < N; i++) begin
      if (first_hot[i]) begin
        first_o = first_o | IW'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/boll_checker.sv =====
// Port-level checks for the bounded ordered list engine, bound to the top.
// Uses boll_pkg for field widths.
module boll_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          ok_o,
  input logic [boll_pkg::RPOS_W-1:0]   result_position_o,
  input logic [boll_pkg::VALUE_W-1:0]  read_value_o,
  input logic [boll_pkg::CNT_W-1:0]    removed_count_o,
  input logic [boll_pkg::CNT_W-1:0]    item_count_o,
  input logic                          is_empty_o
);

  localparam logic [boll_pkg::CNT_W+3:0] CapLim = (boll_pkg::CNT_W+4)'(CAPACITY);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (item_count_o == '0)))
    else $error("is_empty disagrees with item_count");

  // a failed command reports no data
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |->
      (result_position_o == '0) && (read_value_o == '0) && (removed_count_o == '0))
    else $error("failed command carries data");

  // the list never grows past its storage
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((boll_pkg::CNT_W+4)'(item_count_o) <= CapLim))
    else $error("item_count beyond capacity");

endmodule

bind bounded_ordered_list_engine boll_checker #(
  .CAPACITY (CAPACITY)
) u_boll_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .ok_o              (ok_o),
  .result_position_o (result_position_o),
  .read_value_o      (read_value_o),
  .removed_count_o   (removed_count_o),
  .item_count_o      (item_count_o),
  .is_empty_o        (is_empty_o)
);
